// File: src/tiqpa_pkg.sv
// ----------------------------------------------------------------------------
// tiqpa_pkg
// Types, widths and latencies shared by the two-image quadratic voxel block.
// ----------------------------------------------------------------------------
package tiqpa_pkg;

  // Field and arithmetic widths
  localparam int VAL_W     = 16;
  localparam int COEF_W    = 48;
  localparam int COEF_FRAC = 24;
  localparam int IDX_W     = 5;
  localparam int NUM_COEFS = 18;
  localparam int TERMS     = 6;
  localparam int QUADS     = 3;
  localparam int PROD_W    = 32;   // a*a, a*b, b*b
  localparam int ACC_W     = 84;   // exact quadratic sum, Q24

  // Quadratic slots in the coefficient table
  localparam int QUAD_MASK = 0;
  localparam int QUAD_MAIN = 1;
  localparam int QUAD_ALT  = 2;

  // Fuzzy product datapath
  localparam int RAD_W       = 64;  // a*b*(D-a)*(D-b), radicand is this times 2^48
  localparam int ROOT_W      = 56;
  localparam int REM_W       = 58;
  localparam int SQRT_STEPS  = 4;
  localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;
  localparam int NUM_W       = 56;
  localparam int DVS_W       = 17;
  localparam int DIV_STEPS   = 8;
  localparam int DIV_STAGES  = NUM_W / DIV_STEPS;
  localparam int DEN_W       = 18;
  localparam int FZ_W        = ROOT_W + 2;

  // Pipeline positions, counted from the input register
  localparam int QUAD_STAGES = 5;
  localparam int FZ_STAGE    = 2 + SQRT_STAGES + 1 + DIV_STAGES + 1;
  localparam int QUAD_DELAY  = FZ_STAGE - QUAD_STAGES;

  localparam logic [16:0]           FULL_SCALE = 17'd65534;
  localparam logic signed [FZ_W-1:0] FUZZY_MID = {18'd0, 16'd32767, 24'd0};
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC - 1);

  typedef enum logic {
    CMD_EVAL  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic {
    CFG_FUZZY_MODE    = 1'b0,
    CFG_NARROW_OUTPUT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    cmd_t                     command;
    logic [VAL_W-1:0]         value_a;
    logic [VAL_W-1:0]         value_b;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;
  } item_t;

  typedef struct packed {
    logic [VAL_W-1:0] result_value;
    logic             inside_mask;
  } result_t;

  typedef struct packed {
    logic                    mask_hit;
    logic signed [ACC_W-1:0] value;
  } quad_res_t;

endpackage

// File: src/tiqpa_delay.sv
// ----------------------------------------------------------------------------
// tiqpa_delay
// Fixed-depth register line that moves with the pipeline advance.
// ----------------------------------------------------------------------------
module tiqpa_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             adv,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (adv) begin
      line[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign dout = line[DEPTH-1];

endmodule

// File: src/tiqpa_quad.sv
// ----------------------------------------------------------------------------
// tiqpa_quad
// Coefficient table and five-stage evaluation of the three quadratics.
// ----------------------------------------------------------------------------
module tiqpa_quad (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 item_vld,
  input  tiqpa_pkg::item_t     item,
  output tiqpa_pkg::quad_res_t res
);
  import tiqpa_pkg::*;

  // stage 1: term multipliers and the pending table write
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_idx;
  logic signed [COEF_W-1:0]  wr_val;
  logic [PROD_W-1:0]         mult [TERMS];

  logic signed [COEF_W-1:0]  coef [NUM_COEFS];

  // stages 2..5
  logic [PROD_W+COEF_FRAC-1:0]         plo  [NUM_COEFS];
  logic signed [PROD_W+COEF_W-COEF_FRAC:0] phi [NUM_COEFS];
  logic signed [ACC_W-1:0]             term [NUM_COEFS];
  logic signed [ACC_W-1:0]             pair [NUM_COEFS/2];
  logic signed [ACC_W-1:0]             sum  [QUADS];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_en <= 1'b0;
    end else if (adv) begin
      wr_en <= item_vld && (item.command == CMD_WRITE) &&
               (item.coef_index < IDX_W'(NUM_COEFS));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wr_idx  <= item.coef_index;
      wr_val  <= item.coef_value;
      mult[0] <= PROD_W'(item.value_a) * PROD_W'(item.value_a);
      mult[1] <= PROD_W'(item.value_a) * PROD_W'(item.value_b);
      mult[2] <= PROD_W'(item.value_b) * PROD_W'(item.value_b);
      mult[3] <= PROD_W'(item.value_a);
      mult[4] <= PROD_W'(item.value_b);
      mult[5] <= PROD_W'(1);
    end
  end

  // Table is written from stage 1, the same stage that reads it, so
  // writes and evaluations keep their order.
  always_ff @(posedge clk) begin
    if (adv && wr_en) begin
      coef[wr_idx] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_COEFS; k++) begin
        plo[k]  <= (PROD_W+COEF_FRAC)'(coef[k][COEF_FRAC-1:0]) *
                   (PROD_W+COEF_FRAC)'(mult[k % TERMS]);
        phi[k]  <= $signed(coef[k][COEF_W-1:COEF_FRAC]) *
                   $signed({1'b0, mult[k % TERMS]});
        term[k] <= (ACC_W'(phi[k]) <<< COEF_FRAC) + $signed(ACC_W'(plo[k]));
      end
      for (int j = 0; j < NUM_COEFS/2; j++) begin
        pair[j] <= term[2*j] + term[2*j+1];
      end
      for (int q = 0; q < QUADS; q++) begin
        sum[q] <= pair[3*q] + pair[3*q+1] + pair[3*q+2];
      end
    end
  end

  always_comb begin
    res.mask_hit = !sum[QUAD_MASK][ACC_W-1] && (sum[QUAD_MASK] != '0);
    res.value    = res.mask_hit ? sum[QUAD_MAIN] : sum[QUAD_ALT];
  end

endmodule

// File: src/tiqpa_sqrt.sv
// ----------------------------------------------------------------------------
// tiqpa_sqrt
// Pipelined restoring square root of rad * 2^48, four root bits per stage.
// ----------------------------------------------------------------------------
module tiqpa_sqrt (
  input  logic                           clk,
  input  logic                           adv,
  input  logic [tiqpa_pkg::RAD_W-1:0]    rad,
  output logic [tiqpa_pkg::ROOT_W-1:0]   root
);
  import tiqpa_pkg::*;

  logic [RAD_W-1:0]  rad_r     [SQRT_STAGES];
  logic [REM_W-1:0]  rem_r     [SQRT_STAGES];
  logic [ROOT_W-1:0] root_r    [SQRT_STAGES];
  logic [RAD_W-1:0]  rad_next  [SQRT_STAGES];
  logic [REM_W-1:0]  rem_next  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_next [SQRT_STAGES];

  always_comb begin
    logic [RAD_W-1:0]  rd;
    logic [REM_W-1:0]  rm;
    logic [ROOT_W-1:0] rt;
    logic [REM_W+1:0]  rs;
    logic [REM_W+1:0]  tr;
    for (int s = 0; s < SQRT_STAGES; s++) begin
      if (s == 0) begin
        rd = rad;
        rm = '0;
        rt = '0;
      end else begin
        rd = rad_r[s-1];
        rm = rem_r[s-1];
        rt = root_r[s-1];
      end
      for (int j = 0; j < SQRT_STEPS; j++) begin
        rs = {rm, rd[RAD_W-1 -: 2]};
        tr = {2'b00, rt, 2'b01};
        if (rs >= tr) begin
          rm = REM_W'(rs - tr);
          rt = {rt[ROOT_W-2:0], 1'b1};
        end else begin
          rm = REM_W'(rs);
          rt = {rt[ROOT_W-2:0], 1'b0};
        end
        rd = rd << 2;   // low radicand bits are zero once rad is used up
      end
      rad_next[s]  = rd;
      rem_next[s]  = rm;
      root_next[s] = rt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
        rad_r[s]  <= rad_next[s];
        rem_r[s]  <= rem_next[s];
        root_r[s] <= root_next[s];
      end
    end
  end

  assign root = root_r[SQRT_STAGES-1];

endmodule

// File: src/tiqpa_div.sv
// ----------------------------------------------------------------------------
// tiqpa_div
// Pipelined restoring divider, 56-bit magnitude by 17-bit, 8 bits per stage.
// ----------------------------------------------------------------------------
module tiqpa_div (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [tiqpa_pkg::NUM_W-1:0]  num,
  input  logic [tiqpa_pkg::DVS_W-1:0]  dvs,
  output logic [tiqpa_pkg::NUM_W-1:0]  quo
);
  import tiqpa_pkg::*;

  // nq: numerator bits shift out the top while quotient bits enter below
  logic [NUM_W-1:0] nq_r    [DIV_STAGES];
  logic [DVS_W-1:0] rm_r    [DIV_STAGES];
  logic [DVS_W-1:0] dv_r    [DIV_STAGES];
  logic [NUM_W-1:0] nq_next [DIV_STAGES];
  logic [DVS_W-1:0] rm_next [DIV_STAGES];

  always_comb begin
    logic [NUM_W-1:0] nq;
    logic [DVS_W-1:0] rm;
    logic [DVS_W-1:0] dv;
    logic [DVS_W:0]   rs;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        nq = num;
        rm = '0;
        dv = dvs;
      end else begin
        nq = nq_r[s-1];
        rm = rm_r[s-1];
        dv = dv_r[s-1];
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
        rs = {rm, nq[NUM_W-1]};
        nq = {nq[NUM_W-2:0], 1'b0};
        if (rs >= {1'b0, dv}) begin
          rm    = DVS_W'(rs - {1'b0, dv});
          nq[0] = 1'b1;
        end else begin
          rm = DVS_W'(rs);
        end
      end
      nq_next[s] = nq;
      rm_next[s] = rm;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nq_r[0] <= nq_next[0];
      rm_r[0] <= rm_next[0];
      dv_r[0] <= dvs;
      for (int s = 1; s < DIV_STAGES; s++) begin
        nq_r[s] <= nq_next[s];
        rm_r[s] <= rm_next[s];
        dv_r[s] <= dv_r[s-1];
      end
    end
  end

  assign quo = nq_r[DIV_STAGES-1];

endmodule

// File: src/two_image_quadratic_pixel_algebra.sv
// ----------------------------------------------------------------------------
// two_image_quadratic_pixel_algebra
// Per-voxel quadratic algebra on two images with optional fuzzy product.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+---------------------------------
//   item     | item_valid / item_stall     | tiqpa_pkg::item_t
//   result   | result_valid / result_stall | tiqpa_pkg::result_t
//   cfg      | cfg_write                   | cfg_index, cfg_data
//
// One item per cycle while item_stall is low. An evaluate item gives its
// result once it has passed the fuzzy path (14-stage square root and
// 7-stage divider), which sets the pipeline length. Coefficient writes give no result.
// Reset clears valids and both config bits; the coefficient table is
// undefined until written.
// result_stall with a result waiting freezes the whole pipeline; item_stall
// follows it in the same cycle.
// ----------------------------------------------------------------------------
module two_image_quadratic_pixel_algebra (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  tiqpa_pkg::item_t       item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output tiqpa_pkg::result_t     result,
  input  logic                   cfg_write,
  input  tiqpa_pkg::cfg_index_t  cfg_index,
  input  logic                   cfg_data
);
  import tiqpa_pkg::*;

  // Global advance: all stages move together when the output slot frees.
  logic adv;
  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;

  // Config registers
  logic fuzzy_mode;
  logic narrow_output;

  always_ff @(posedge clk) begin
    if (rst) begin
      fuzzy_mode    <= 1'b0;
      narrow_output <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FUZZY_MODE:    fuzzy_mode    <= cfg_data;
        CFG_NARROW_OUTPUT: narrow_output <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register (stage 0)
  logic  s0_vld;
  item_t s0_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (adv) begin
      s0_vld <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_item <= item;
    end
  end

  // Result-producing valid bits, vpipe[k] belongs to stage k+1
  logic [FZ_STAGE-1:0] vpipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (adv) begin
      vpipe <= {vpipe[FZ_STAGE-2:0], s0_vld && (s0_item.command == CMD_EVAL)};
    end
  end

  // Quadratics: ready at stage 5, held until the fuzzy path catches up
  quad_res_t quad_res;
  quad_res_t quad_d;

  tiqpa_quad u_quad (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .item_vld (s0_vld),
    .item     (s0_item),
    .res      (quad_res)
  );

  tiqpa_delay #(
    .WIDTH ($bits(quad_res_t)),
    .DEPTH (QUAD_DELAY)
  ) u_quad_dly (
    .clk  (clk),
    .adv  (adv),
    .din  (quad_res),
    .dout (quad_d)
  );

  // Fuzzy path, stage 1: a*b, (D-a)*(D-b), D-a-b
  logic signed [DEN_W-1:0]   fu;
  logic signed [DEN_W-1:0]   fv;
  logic [PROD_W-1:0]         f1_ab;
  logic signed [2*DEN_W-1:0] f1_uv;
  logic signed [DEN_W-1:0]   f1_den;

  assign fu = $signed({1'b0, FULL_SCALE}) - $signed({2'b00, s0_item.value_a});
  assign fv = $signed({1'b0, FULL_SCALE}) - $signed({2'b00, s0_item.value_b});

  // stage 2: P = a*b*(D-a)*(D-b), zero when the second factor is not positive
  logic [RAD_W-1:0]        f2_p;
  logic [PROD_W-1:0]       f2_ab;
  logic signed [DEN_W-1:0] f2_den;

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_ab  <= PROD_W'(s0_item.value_a) * PROD_W'(s0_item.value_b);
      f1_uv  <= fu * fv;
      f1_den <= fu - $signed({2'b00, s0_item.value_b});
      f2_p   <= (f1_uv[2*DEN_W-1] || (f1_uv == '0)) ? '0 :
                RAD_W'(f1_ab) * RAD_W'(f1_uv[PROD_W-1:0]);
      f2_ab  <= f1_ab;
      f2_den <= f1_den;
    end
  end

  // stages 3..16: root of P * 2^48
  logic [ROOT_W-1:0]       sq_root;
  logic [PROD_W-1:0]       d_ab;
  logic signed [DEN_W-1:0] d_den;

  tiqpa_sqrt u_sqrt (
    .clk  (clk),
    .adv  (adv),
    .rad  (f2_p),
    .root (sq_root)
  );

  tiqpa_delay #(
    .WIDTH (PROD_W + DEN_W),
    .DEPTH (SQRT_STAGES)
  ) u_sq_dly (
    .clk  (clk),
    .adv  (adv),
    .din  ({f2_ab, f2_den}),
    .dout ({d_ab, d_den})
  );

  // stage 17: numerator |root - a*b| and divisor |D-a-b| with signs split off
  logic [NUM_W-1:0] abq;
  logic             nneg;
  logic [NUM_W-1:0] p_nmag;
  logic [DVS_W-1:0] p_dmag;
  logic             p_neg;
  logic             p_dz;

  assign abq  = {d_ab, {COEF_FRAC{1'b0}}};
  assign nneg = sq_root < abq;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_nmag <= nneg ? (abq - sq_root) : (sq_root - abq);
      p_dmag <= d_den[DEN_W-1] ? DVS_W'(-d_den) : DVS_W'(d_den);
      p_neg  <= nneg ^ d_den[DEN_W-1];
      p_dz   <= (d_den == '0);
    end
  end

  // stages 18..24: quotient, truncated toward zero
  logic [NUM_W-1:0] dv_quo;
  logic             dn_neg;
  logic             dn_dz;

  tiqpa_div u_div (
    .clk (clk),
    .adv (adv),
    .num (p_nmag),
    .dvs (p_dmag),
    .quo (dv_quo)
  );

  tiqpa_delay #(
    .WIDTH (2),
    .DEPTH (DIV_STAGES)
  ) u_div_dly (
    .clk  (clk),
    .adv  (adv),
    .din  ({p_neg, p_dz}),
    .dout ({dn_neg, dn_dz})
  );

  // stage 25: signed fuzzy value in Q24; zero denominator gives the midpoint
  logic signed [FZ_W-1:0] fz;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dn_dz) begin
        fz <= FUZZY_MID;
      end else if (dn_neg) begin
        fz <= -$signed({2'b00, dv_quo});
      end else begin
        fz <= $signed({2'b00, dv_quo});
      end
    end
  end

  // stage 26: select, round half up, clamp, narrow -> output register
  logic signed [ACC_W-1:0] sel_val;
  logic signed [ACC_W-1:0] rounded;
  logic [VAL_W-1:0]        clamped;
  result_t                 result_next;

  always_comb begin
    sel_val = (quad_d.mask_hit && fuzzy_mode) ? ACC_W'(fz) : quad_d.value;
    rounded = sel_val + ROUND_HALF;
    if (rounded[ACC_W-1]) begin
      clamped = '0;
    end else if (|rounded[ACC_W-2:COEF_FRAC+VAL_W]) begin
      clamped = '1;
    end else begin
      clamped = rounded[COEF_FRAC+VAL_W-1:COEF_FRAC];
    end
    result_next.result_value = narrow_output ? {8'd0, clamped[7:0]} : clamped;
    result_next.inside_mask  = quad_d.mask_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= vpipe[FZ_STAGE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= result_next;
    end
  end

  // Checks
  a_narrow: assert property (@(posedge clk) disable iff (rst)
    result_valid && narrow_output |-> result.result_value[15:8] == 8'd0)
    else $error("narrowed result has high bits set");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    adv && s0_vld && (s0_item.command == CMD_WRITE) |=> !vpipe[0])
    else $error("coefficient write started a result");

  a_last_stage: assert property (@(posedge clk) disable iff (rst)
    adv && vpipe[FZ_STAGE-1] |=> result_valid)
    else $error("finished item lost before output register");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(vpipe))
    else $error("pipeline moved while output stalled");

endmodule
